### hdl/multi_level_priority_queue_defines.svh
// assertion macros for the multi-level priority queue
// used by the top level only; expects i_clk and i_rst_n in scope
`ifndef MULTI_LEVEL_PRIORITY_QUEUE_DEFINES_SVH
`define MULTI_LEVEL_PRIORITY_QUEUE_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define MLPQ_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// implication whose consequent is checked on the next clock
`define MLPQ_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/mlpq_pkg.sv
// shared constants, widths and codes for the multi-level priority queue
// no dependencies
package mlpq_pkg;

    localparam int NUM_LEVELS  = 4;
    localparam int LEVEL_DEPTH = 16;
    localparam int TASK_WIDTH  = 32;

    localparam int LVL_W       = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int PTR_W       = $clog2(LEVEL_DEPTH);
    localparam int CNT_W       = $clog2(LEVEL_DEPTH + 1);
    localparam int STORE_DEPTH = NUM_LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int TOT_W       = $clog2(STORE_DEPTH + 1);

    // fixed field widths
    localparam int CMD_W    = 2;
    localparam int PRIO_W   = 8;
    localparam int DATA_W   = 32;
    localparam int LEN_W    = 5;
    localparam int STAT_W   = 2;
    localparam int LIU_W    = 3;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    // register indexes
    localparam logic [2:0] REG_LEVELS_IN_USE = 3'd0;
    localparam logic [2:0] REG_LEVEL_PRIO0   = 3'd1;
    localparam int         NUM_PRIO_REGS     = 4;

    localparam logic [LIU_W-1:0] LEVELS_IN_USE_RST = 3'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_PEEK = 2'd2,
        CMD_LEN  = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_NOPRIO = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

endpackage

### hdl/mlpq_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module mlpq_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/multi_level_priority_queue.sv
// multi-level priority queue: one fifo of task words per level in a shared ram
// data path: an accepted item passes the decision register, beside the registered ram read,
// and then the result register
// throughput: one item per cycle, level selection and the queue state update finish in the
// accepting cycle; a stalled result holds the input back once stage one is also full
// reset (i_rst_n low, synchronous): all levels emptied, pipeline flushed,
// levels_in_use back to 4 and level priorities back to 0..3; the task ram is not cleared
`include "multi_level_priority_queue_defines.svh"

module multi_level_priority_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [mlpq_pkg::CMD_W-1:0]    i_command,
    input  logic [mlpq_pkg::PRIO_W-1:0]   i_task_priority,
    input  logic [mlpq_pkg::DATA_W-1:0]   i_task_data,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mlpq_pkg::DATA_W-1:0]   o_out_task_data,
    output logic [mlpq_pkg::PRIO_W-1:0]   o_out_priority,
    output logic [mlpq_pkg::LEN_W-1:0]    o_level_length,
    output logic                          o_all_empty,
    output logic [mlpq_pkg::STAT_W-1:0]   o_status,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mlpq_pkg::PADDR_W-1:0]  paddr,
    input  logic [mlpq_pkg::PDATA_W-1:0]  pwdata,
    output logic [mlpq_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    import mlpq_pkg::*;

    // configuration
    logic [LIU_W-1:0]  r_levels_in_use;
    logic [PRIO_W-1:0] r_prio [NUM_LEVELS];

    // queue state
    logic [PTR_W-1:0]  r_head  [NUM_LEVELS];
    logic [PTR_W-1:0]  r_tail  [NUM_LEVELS];
    logic [CNT_W-1:0]  r_count [NUM_LEVELS];
    logic [PTR_W-1:0]  n_head  [NUM_LEVELS];
    logic [PTR_W-1:0]  n_tail  [NUM_LEVELS];
    logic [CNT_W-1:0]  n_count [NUM_LEVELS];

    // stage one (after the decision)
    logic              r_s1_valid;
    logic              r_s1_use_data;
    logic [PRIO_W-1:0] r_s1_prio;
    logic [LEN_W-1:0]  r_s1_len;
    logic              r_s1_empty;
    t_status           r_s1_status;

    // result register
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic [PRIO_W-1:0] r_out_prio;
    logic [LEN_W-1:0]  r_out_len;
    logic              r_out_empty;
    t_status           r_out_status;

    logic              n_s1_use_data;
    logic [PRIO_W-1:0] n_s1_prio;
    logic [LEN_W-1:0]  n_s1_len;
    logic              n_s1_empty;
    t_status           n_s1_status;

    logic                  w_cfg_wr;
    logic [2:0]            w_cfg_idx;
    logic                  w_accept;
    logic                  w_out_adv;
    t_cmd                  w_cmd;
    logic [NUM_LEVELS-1:0] w_active;

    logic              w_fnd;
    logic [LVL_W-1:0]  w_fidx;
    logic [CNT_W-1:0]  w_fcnt;
    logic [PTR_W-1:0]  w_ftail;
    logic              w_bfnd;
    logic [LVL_W-1:0]  w_bidx;
    logic [PRIO_W-1:0] w_bprio;
    logic [PTR_W-1:0]  w_bhead;

    logic              w_push_ok;
    logic              w_pop_ok;
    logic              w_rd_en;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [63:0]       w_wr_wide;
    logic [TASK_WIDTH-1:0] w_rd_data;
    logic [63:0]       w_rd_wide;
    logic [TOT_W-1:0]  w_total;

    // configuration port
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels_in_use <= LEVELS_IN_USE_RST;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_prio[i] <= PRIO_W'(i);
            end
        end else if (w_cfg_wr) begin
            if (w_cfg_idx == REG_LEVELS_IN_USE) begin
                r_levels_in_use <= pwdata[LIU_W-1:0];
            end
            for (int i = 0; i < NUM_LEVELS; i++) begin
                if (i < NUM_PRIO_REGS && w_cfg_idx == REG_LEVEL_PRIO0 + 3'(i)) begin
                    r_prio[i] <= pwdata[PRIO_W-1:0];
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (w_cfg_idx == REG_LEVELS_IN_USE) begin
            prdata = PDATA_W'(r_levels_in_use);
        end
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (i < NUM_PRIO_REGS && w_cfg_idx == REG_LEVEL_PRIO0 + 3'(i)) begin
                prdata = PDATA_W'(r_prio[i]);
            end
        end
    end

    // handshake
    assign w_out_adv  = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || w_out_adv;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_cmd      = t_cmd'(i_command);

    // level selection
    always_comb begin
        w_fnd   = 1'b0;
        w_fidx  = '0;
        w_fcnt  = '0;
        w_ftail = '0;
        w_bfnd  = 1'b0;
        w_bidx  = '0;
        w_bprio = '0;
        w_bhead = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            w_active[i] = 4'(i) < 4'(r_levels_in_use);
            // first active level whose priority matches
            if (!w_fnd && w_active[i] && r_prio[i] == i_task_priority) begin
                w_fnd   = 1'b1;
                w_fidx  = LVL_W'(i);
                w_fcnt  = r_count[i];
                w_ftail = r_tail[i];
            end
            // highest priority non-empty level, strict compare keeps lowest index on ties
            if (w_active[i] && r_count[i] != '0 && (!w_bfnd || r_prio[i] > w_bprio)) begin
                w_bfnd  = 1'b1;
                w_bidx  = LVL_W'(i);
                w_bprio = r_prio[i];
                w_bhead = r_head[i];
            end
        end
    end

    always_comb begin
        n_s1_use_data = 1'b0;
        n_s1_prio     = '0;
        n_s1_len      = '0;
        n_s1_status   = ST_OK;
        w_push_ok     = 1'b0;
        w_pop_ok      = 1'b0;
        w_rd_en       = 1'b0;
        case (w_cmd)
            CMD_PUSH: begin
                if (!w_fnd) begin
                    n_s1_status = ST_NOPRIO;
                end else if (w_fcnt >= CNT_W'(LEVEL_DEPTH)) begin
                    n_s1_status = ST_FULL;
                end else begin
                    w_push_ok = w_accept;
                end
            end
            CMD_POP, CMD_PEEK: begin
                if (!w_bfnd) begin
                    n_s1_status = ST_EMPTY;
                end else begin
                    n_s1_use_data = 1'b1;
                    n_s1_prio     = w_bprio;
                    w_rd_en       = w_accept;
                    w_pop_ok      = w_accept && (w_cmd == CMD_POP);
                end
            end
            CMD_LEN: begin
                if (!w_fnd) begin
                    n_s1_status = ST_NOPRIO;
                end else begin
                    n_s1_len = LEN_W'(w_fcnt);
                end
            end
            default: begin
                n_s1_status = ST_OK;
            end
        endcase
    end

    // next queue state and all-empty flag after this item
    always_comb begin
        n_s1_empty = 1'b1;
        w_total    = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            n_head[i]  = r_head[i];
            n_tail[i]  = r_tail[i];
            n_count[i] = r_count[i];
            if (w_push_ok && w_fidx == LVL_W'(i)) begin
                n_tail[i]  = (r_tail[i] == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : r_tail[i] + 1'b1;
                n_count[i] = r_count[i] + 1'b1;
            end
            if (w_pop_ok && w_bidx == LVL_W'(i)) begin
                n_head[i]  = (r_head[i] == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : r_head[i] + 1'b1;
                n_count[i] = r_count[i] - 1'b1;
            end
            if (w_active[i] && n_count[i] != '0) begin
                n_s1_empty = 1'b0;
            end
            w_total = w_total + TOT_W'(r_count[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
        end else if (w_accept) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_head[i]  <= n_head[i];
                r_tail[i]  <= n_tail[i];
                r_count[i] <= n_count[i];
            end
        end
    end

    // task store
    assign w_wr_wide = 64'(i_task_data);
    assign w_wr_addr = ADDR_W'(w_fidx) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(w_ftail);
    assign w_rd_addr = ADDR_W'(w_bidx) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(w_bhead);

    mlpq_ram #(
        .WIDTH  (TASK_WIDTH),
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_task_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_push_ok),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_wide[TASK_WIDTH-1:0]),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_rd_wide = 64'(w_rd_data);

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_use_data <= n_s1_use_data;
            r_s1_prio     <= n_s1_prio;
            r_s1_len      <= n_s1_len;
            r_s1_empty    <= n_s1_empty;
            r_s1_status   <= n_s1_status;
        end
        if (w_out_adv && r_s1_valid) begin
            // ram read data is held while stage one waits, no new read is issued
            r_out_data   <= r_s1_use_data ? w_rd_wide[DATA_W-1:0] : '0;
            r_out_prio   <= r_s1_prio;
            r_out_len    <= r_s1_len;
            r_out_empty  <= r_s1_empty;
            r_out_status <= r_s1_status;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_task_data = r_out_data;
    assign o_out_priority  = r_out_prio;
    assign o_level_length  = r_out_len;
    assign o_all_empty     = r_out_empty;
    assign o_status        = r_out_status;

    // checks
    `MLPQ_ASSERT_NEXT(a_pop_takes_one, w_pop_ok, w_total == $past(w_total) - 1'b1, "pop did not remove exactly one task")
    `MLPQ_ASSERT_NEXT(a_peek_keeps_fill, w_accept && w_cmd == CMD_PEEK, w_total == $past(w_total), "peek changed the fill")
    `MLPQ_ASSERT(a_empty_flag, !(r_out_valid && r_out_status == ST_EMPTY) || r_out_empty, "nothing queued without all-empty flag")

endmodule

### dv/tb_multi_level_priority_queue.sv
// self-checking testbench for the multi-level priority queue
// depends on mlpq_pkg and the multi_level_priority_queue rtl; predicts every result
// from its own copy of the per-level fifos and checks each result in order
module tb_multi_level_priority_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import mlpq_pkg::*;

    localparam int         LIMIT_CYCLES = 400_000;
    localparam logic [2:0] REG_UNMAPPED = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0] task_data;
        logic [PRIO_W-1:0] prio;
        logic [LEN_W-1:0]  length;
        logic              all_empty;
        t_status           status;
    } t_queue_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [CMD_W-1:0]    i_command = '0;
    logic [PRIO_W-1:0]   i_task_priority = '0;
    logic [DATA_W-1:0]   i_task_data = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [DATA_W-1:0]   o_out_task_data;
    logic [PRIO_W-1:0]   o_out_priority;
    logic [LEN_W-1:0]    o_level_length;
    logic                o_all_empty;
    logic [STAT_W-1:0]   o_status;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    multi_level_priority_queue dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_task_priority (i_task_priority),
        .i_task_data     (i_task_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_task_data (o_out_task_data),
        .o_out_priority  (o_out_priority),
        .o_level_length  (o_level_length),
        .o_all_empty     (o_all_empty),
        .o_status        (o_status),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // shadow of the queue state and its registers
    logic [DATA_W-1:0]  lvl_mem [NUM_LEVELS][LEVEL_DEPTH];
    int unsigned        lvl_head [NUM_LEVELS];
    int unsigned        lvl_tail [NUM_LEVELS];
    int unsigned        lvl_fill [NUM_LEVELS];
    logic [LIU_W-1:0]   cfg_levels;
    logic [PRIO_W-1:0]  cfg_prio [NUM_LEVELS];

    t_queue_result      awaited_results [$];
    int unsigned        fail_count = 0;
    int unsigned        items_sent = 0;
    int unsigned        results_checked = 0;
    int unsigned        settings_used = 0;
    int unsigned        status_seen [4];
    int unsigned        cycle_count = 0;

    bit                 calm = 1'b0;
    int unsigned        hold_request = 0;
    int unsigned        rx_hold_left = 0;
    int unsigned        rx_gap_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("multi_level_priority_queue verification failed");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off when a test asks for one
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            rx_hold_left = hold_request;
            hold_request = 0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            i_out_ready <= 1'b0;
        end else if (calm) begin
            i_out_ready <= 1'b1;
        end else if (rx_gap_left != 0) begin
            rx_gap_left--;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 11) == 0) begin
            rx_gap_left = $urandom_range(0, 18);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic void check_field(string name, logic [DATA_W-1:0] expv,
                                        logic [DATA_W-1:0] got);
        if (got !== expv) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, expv, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_queue_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                $error("result item arrived with nothing outstanding");
                fail_count++;
            end else begin
                want = awaited_results.pop_front();
                check_field("out_task_data", want.task_data, o_out_task_data);
                check_field("out_priority", want.prio, o_out_priority);
                check_field("level_length", want.length, o_level_length);
                check_field("all_empty", want.all_empty, o_all_empty);
                check_field("status", want.status, o_status);
                results_checked++;
            end
        end
    end

    function automatic int unsigned active_count();
        return (cfg_levels > NUM_LEVELS) ? NUM_LEVELS : cfg_levels;
    endfunction

    // first active level serving this priority, -1 if none
    function automatic int match_level(logic [PRIO_W-1:0] prio);
        for (int i = 0; i < active_count(); i++)
            if (cfg_prio[i] == prio)
                return i;
        return -1;
    endfunction

    function automatic int unsigned queued_total();
        int unsigned sum;
        sum = 0;
        for (int i = 0; i < active_count(); i++)
            sum += lvl_fill[i];
        return sum;
    endfunction

    function automatic t_queue_result queue_step(t_cmd cmd, logic [PRIO_W-1:0] prio,
                                                 logic [DATA_W-1:0] data);
        t_queue_result r;
        int lv;
        r = '0;
        r.status = ST_OK;
        lv = -1;
        case (cmd)
            CMD_PUSH: begin
                lv = match_level(prio);
                if (lv < 0) begin
                    r.status = ST_NOPRIO;
                end else if (lvl_fill[lv] >= LEVEL_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    lvl_mem[lv][lvl_tail[lv]] = data;
                    lvl_tail[lv] = (lvl_tail[lv] + 1) % LEVEL_DEPTH;
                    lvl_fill[lv]++;
                end
            end
            CMD_POP, CMD_PEEK: begin
                // highest priority value wins, lowest index on a tie
                for (int i = 0; i < active_count(); i++)
                    if (lvl_fill[i] != 0 && (lv < 0 || cfg_prio[i] > cfg_prio[lv]))
                        lv = i;
                if (lv < 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.task_data = lvl_mem[lv][lvl_head[lv]];
                    r.prio = cfg_prio[lv];
                    if (cmd == CMD_POP) begin
                        lvl_head[lv] = (lvl_head[lv] + 1) % LEVEL_DEPTH;
                        lvl_fill[lv]--;
                    end
                end
            end
            default: begin
                lv = match_level(prio);
                if (lv < 0)
                    r.status = ST_NOPRIO;
                else
                    r.length = LEN_W'(lvl_fill[lv]);
            end
        endcase
        r.all_empty = (queued_total() == 0);
        return r;
    endfunction

    task automatic send_item(t_cmd cmd, logic [PRIO_W-1:0] prio, logic [DATA_W-1:0] data);
        t_queue_result r;
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_task_priority <= prio;
        i_task_data <= data;
        do @(posedge i_clk); while (!o_in_ready);
        r = queue_step(cmd, prio, data);
        awaited_results.push_back(r);
        items_sent++;
        status_seen[r.status]++;
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    task automatic send_random(int push_pct, int pop_pct, int peek_pct);
        int roll;
        t_cmd cmd;
        logic [PRIO_W-1:0] prio;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            cmd = CMD_PUSH;
        else if (roll < push_pct + pop_pct)
            cmd = CMD_POP;
        else if (roll < push_pct + pop_pct + peek_pct)
            cmd = CMD_PEEK;
        else
            cmd = CMD_LEN;
        // mostly priorities that some level serves
        if ($urandom_range(0, 4) == 0)
            prio = PRIO_W'($urandom_range(0, 255));
        else
            prio = cfg_prio[$urandom_range(0, NUM_LEVELS - 1)];
        send_item(cmd, prio, $urandom);
    endtask

    task automatic run_burst(int count, int push_pct, int pop_pct, int peek_pct);
        repeat (count) send_random(push_pct, pop_pct, peek_pct);
    endtask

    task automatic stop_sending();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [PDATA_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(idx * 4);
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_LEVELS_IN_USE)
            cfg_levels = val[LIU_W-1:0];
        else if (idx >= REG_LEVEL_PRIO0 && idx < REG_LEVEL_PRIO0 + NUM_PRIO_REGS
                 && idx - REG_LEVEL_PRIO0 < NUM_LEVELS)
            cfg_prio[idx - REG_LEVEL_PRIO0] = val[PRIO_W-1:0];
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(logic [LIU_W-1:0] levels, logic [PRIO_W-1:0] p0,
                             logic [PRIO_W-1:0] p1, logic [PRIO_W-1:0] p2,
                             logic [PRIO_W-1:0] p3);
        stop_sending();
        wait_drained();
        reg_write(REG_LEVELS_IN_USE, PDATA_W'(levels));
        reg_write(REG_LEVEL_PRIO0, PDATA_W'(p0));
        reg_write(REG_LEVEL_PRIO0 + 3'd1, PDATA_W'(p1));
        reg_write(REG_LEVEL_PRIO0 + 3'd2, PDATA_W'(p2));
        reg_write(REG_LEVEL_PRIO0 + 3'd3, PDATA_W'(p3));
        settings_used++;
    endtask

    function automatic logic [PRIO_W-1:0] pick_prio();
        // a narrow range half the time so duplicates show up
        if ($urandom_range(0, 1) == 0)
            return PRIO_W'($urandom_range(0, 7));
        return PRIO_W'($urandom_range(0, 255));
    endfunction

    task automatic test_reset_defaults();
        send_item(CMD_POP, 8'd0, 32'h0);
        send_item(CMD_PEEK, 8'd3, 32'hFFFF_FFFF);
        send_item(CMD_LEN, 8'd0, 32'h0);
        send_item(CMD_LEN, 8'd255, 32'h0);
        send_item(CMD_PUSH, 8'd200, 32'hDEAD_BEEF);
        send_item(CMD_PUSH, 8'd0, 32'h0000_0000);
        send_item(CMD_PUSH, 8'd3, 32'hFFFF_FFFF);
        send_item(CMD_PUSH, 8'd1, 32'hA5A5_A5A5);
        send_item(CMD_PUSH, 8'd2, 32'h5A5A_5A5A);
        send_item(CMD_PUSH, 8'd3, 32'h1234_5678);
        send_item(CMD_LEN, 8'd3, 32'h0);
        send_item(CMD_PEEK, 8'd0, 32'h0);
        repeat (6) send_item(CMD_POP, 8'd0, 32'h0);
    endtask

    // out-of-range level counts, zero levels, hidden levels, duplicate priorities
    task automatic test_register_corners();
        configure(3'd7, 8'd255, 8'd0, 8'd255, 8'd128);
        reg_write(REG_UNMAPPED, '1);
        run_burst(80, 45, 25, 15);
        configure(3'd1, 8'd255, 8'd128, 8'd0, 8'd7);
        run_burst(60, 60, 15, 10);
        configure(3'd0, 8'd255, 8'd128, 8'd0, 8'd7);
        run_burst(30, 40, 25, 15);
        configure(3'd5, 8'd9, 8'd9, 8'd9, 8'd9);
        run_burst(60, 25, 50, 15);
        configure(3'd4, 8'd0, 8'd255, 8'd1, 8'd254);
        run_burst(80, 45, 25, 15);
    endtask

    task automatic test_level_full();
        int lv;
        configure(3'd4, 8'd20, 8'd40, 8'd60, 8'd80);
        lv = $urandom_range(0, NUM_LEVELS - 1);
        repeat (LEVEL_DEPTH + 4) send_item(CMD_PUSH, cfg_prio[lv], $urandom);
        send_item(CMD_LEN, cfg_prio[lv], $urandom);
        while (queued_total() != 0) send_item(CMD_POP, PRIO_W'($urandom), $urandom);
        send_item(CMD_PEEK, PRIO_W'($urandom), $urandom);
    endtask

    task automatic test_output_backpressure();
        calm = 1'b1;
        hold_request = 300;
        run_burst(70, 55, 25, 10);
        // sender pauses until every outstanding result is back
        stop_sending();
        wait_drained();
        calm = 1'b0;
        run_burst(40, 30, 40, 15);
    endtask

    task automatic test_random_settings();
        repeat (4) begin
            configure(LIU_W'($urandom_range(0, 7)), pick_prio(), pick_prio(),
                      pick_prio(), pick_prio());
            run_burst(50, 60, 20, 10);
            run_burst(50, 30, 45, 10);
        end
    endtask

    task automatic test_full_rate();
        calm = 1'b1;
        configure(3'd4, pick_prio(), pick_prio(), pick_prio(), pick_prio());
        run_burst(150, 45, 30, 10);
        stop_sending();
    endtask

    initial begin
        for (int i = 0; i < NUM_LEVELS; i++) begin
            lvl_head[i] = 0;
            lvl_tail[i] = 0;
            lvl_fill[i] = 0;
            cfg_prio[i] = PRIO_W'(i);
        end
        cfg_levels = LEVELS_IN_USE_RST;
        for (int i = 0; i < 4; i++)
            status_seen[i] = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        settings_used = 1;

        test_reset_defaults();
        test_register_corners();
        test_level_full();
        test_output_backpressure();
        test_random_settings();
        test_full_rate();

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("ran %0d items over %0d register settings, %0d results checked",
                 items_sent, settings_used, results_checked);
        $display("answers: %0d ok, %0d unmatched priority, %0d level full, %0d nothing queued",
                 status_seen[ST_OK], status_seen[ST_NOPRIO], status_seen[ST_FULL],
                 status_seen[ST_EMPTY]);
        if (fail_count == 0)
            $display("multi_level_priority_queue verification clean");
        else
            $display("multi_level_priority_queue verification failed");
        $finish;
    end

endmodule
